### hdl/scrc_pkg.sv
// Shared types and constants for the keyed double SHA-1 challenge/response checker.
// No dependencies; imported by scrc_sha1_core, the top level and the bench.
package scrc_pkg;

    localparam int unsigned BLOCK_BITS  = 512;
    localparam int unsigned DIGEST_BITS = 160;
    localparam int unsigned CFG_IDX_W   = 8;

    // message is 16 key bytes plus 20 data bytes
    localparam logic [31:0] MSG_BIT_LEN = 32'd288;
    localparam logic [31:0] PAD_WORD    = 32'h8000_0000;

    localparam logic [31:0] IV_A = 32'h6745_2301;
    localparam logic [31:0] IV_B = 32'hEFCD_AB89;
    localparam logic [31:0] IV_C = 32'h98BA_DCFE;
    localparam logic [31:0] IV_D = 32'h1032_5476;
    localparam logic [31:0] IV_E = 32'hC3D2_E1F0;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A_UPPER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A_LOWER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B_UPPER = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B_LOWER = 8'd3;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } t_core_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START1,
        ST_RUN1,
        ST_START2,
        ST_RUN2,
        ST_DONE
    } t_top_state;

endpackage

### hdl/scrc_sha1_core.sv
// Iterative SHA-1 compression of one 512-bit block from the standard IV.
// One round per cycle with a rolling 16-word schedule window. Uses scrc_pkg.
module scrc_sha1_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [scrc_pkg::BLOCK_BITS-1:0]   i_block,   // word 0 in the top bits
    output logic                              o_done,
    output logic [scrc_pkg::DIGEST_BITS-1:0]  o_digest   // h0 in the top bits
);
    import scrc_pkg::*;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    t_core_state r_state, n_state;
    logic [6:0]  r_round;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [DIGEST_BITS-1:0] r_digest;
    logic        r_done;

    logic [31:0] f_val, k_val, t_val, w_new;
    logic        ld_start, do_round, do_final;

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = 32'h5A82_7999;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = 32'h6ED9_EBA1;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = 32'h8F1B_BCDC;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = 32'hCA62_C1D6;
        end
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];

    // window holds W[i..i+15]; W[i+16] from taps 13, 8, 2, 0
    logic [31:0] w_x;
    assign w_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_new = {w_x[30:0], w_x[31]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CORE_IDLE:  if (i_start) n_state = CORE_ROUND;
            CORE_ROUND: if (r_round == LAST_ROUND) n_state = CORE_FINAL;
            CORE_FINAL: n_state = CORE_IDLE;
            default:    n_state = CORE_IDLE;
        endcase
    end

    always_comb begin
        ld_start = 1'b0;
        do_round = 1'b0;
        do_final = 1'b0;
        unique case (r_state)
            CORE_IDLE:  ld_start = i_start;
            CORE_ROUND: do_round = 1'b1;
            CORE_FINAL: do_final = 1'b1;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= do_final;
            if (ld_start)
                r_round <= '0;
            else if (do_round)
                r_round <= r_round + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_start) begin
            for (int i = 0; i < 16; i++)
                r_w[i] <= i_block[BLOCK_BITS-1-32*i -: 32];
            r_a <= IV_A;
            r_b <= IV_B;
            r_c <= IV_C;
            r_d <= IV_D;
            r_e <= IV_E;
        end else if (do_round) begin
            for (int i = 0; i < 15; i++)
                r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (do_final)
            r_digest <= {IV_A + r_a, IV_B + r_b, IV_C + r_c, IV_D + r_d, IV_E + r_e};
    end

    assign o_done   = r_done;
    assign o_digest = r_digest;

endmodule

### hdl/sha1_challenge_response_check.sv
// Top level of the keyed double SHA-1 challenge/response checker.
// Holds the key registers, sequences two passes of scrc_sha1_core, compares
// and registers the result. Uses scrc_pkg.
//
// Usage:
//   Configuration channel: write keys by index (0 key A upper, 1 key A lower,
//   2 key B upper, 3 key B lower); other indexes are dropped. Always ready.
//   Request stream (s_axis): challenge, expected value and mode in tuser.
//   Response stream (m_axis): final digest in tdata, match flag in tuser.
//   Each request computes SHA-1(K || SHA-1(K || C)), one padded block each.
//   Each request takes two passes through the one-round-per-cycle core, each
//   pass being start, 80 rounds, finalize and handoff; the output register is
//   loaded after the second pass. s_axis_tready is high only while the
//   sequencer is idle, so a new request is not taken until the previous one
//   has been handed to the output register.
//   The response sits in an output register, so a new request is taken
//   while an old response waits; a finished digest waits in the core until
//   the output register frees up.
//   Reset clears the keys to zero, drops any request in flight and empties
//   the output register.
module sha1_challenge_response_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [63:0]                         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // challenge_first, challenge_second, challenge_tail,
    // expected_first, expected_second, expected_tail
    input  logic [319:0]                        s_axis_tdata,
    // opcode
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // digest_first, digest_second, digest_tail
    output logic [159:0]                        m_axis_tdata,
    // matched
    output logic [0:0]                          m_axis_tuser
);
    import scrc_pkg::*;

    t_top_state r_state, n_state;

    logic [63:0]  r_key_a_upper, r_key_a_lower, r_key_b_upper, r_key_b_lower;
    logic         r_backup;
    logic [63:0]  r_ku, r_kl;
    logic [159:0] r_chal;
    logic [159:0] r_exp;
    logic         r_out_valid;
    logic [159:0] r_out_data;
    logic         r_out_match;

    logic         core_start, core_done;
    logic [BLOCK_BITS-1:0]  core_block;
    logic [DIGEST_BITS-1:0] core_digest;
    logic         in_ready, load_out, use_second;
    logic         out_free, in_accept, match_val;

    assign in_accept = s_axis_tvalid && in_ready;
    assign out_free  = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_accept) n_state = ST_START1;
            ST_START1: n_state = ST_RUN1;
            ST_RUN1:   if (core_done) n_state = ST_START2;
            ST_START2: n_state = ST_RUN2;
            ST_RUN2:   if (core_done) n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        core_start = 1'b0;
        use_second = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready = 1'b1;
            ST_START1: core_start = 1'b1;
            ST_START2: begin
                core_start = 1'b1;
                use_second = 1'b1;
            end
            ST_DONE:   load_out = out_free;
            default:   ;
        endcase
    end

    // both passes hash key || 20 data bytes as one padded block
    assign core_block = {r_ku, r_kl, (use_second ? core_digest : r_chal),
                         PAD_WORD, 160'd0, MSG_BIT_LEN};

    scrc_sha1_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (core_start),
        .i_block  (core_block),
        .o_done   (core_done),
        .o_digest (core_digest)
    );

    // backup compares digest bytes 12..19, the low 64 bits
    assign match_val = r_backup ? (core_digest[63:0] == r_exp[159:96])
                                : (core_digest == r_exp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_key_a_upper <= '0;
            r_key_a_lower <= '0;
            r_key_b_upper <= '0;
            r_key_b_lower <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_KEY_A_UPPER: r_key_a_upper <= i_cfg_data;
                    CFG_KEY_A_LOWER: r_key_a_lower <= i_cfg_data;
                    CFG_KEY_B_UPPER: r_key_b_upper <= i_cfg_data;
                    CFG_KEY_B_LOWER: r_key_b_lower <= i_cfg_data;
                    default:         ;
                endcase
            end
            if (load_out)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_backup <= s_axis_tuser[0];
            r_ku     <= s_axis_tuser[0] ? r_key_b_upper : r_key_a_upper;
            r_kl     <= s_axis_tuser[0] ? r_key_b_lower : r_key_a_lower;
            // word order: challenge bytes 0..19, tail zeroed in backup mode
            r_chal   <= {s_axis_tdata[63:0], s_axis_tdata[127:64],
                         (s_axis_tuser[0] ? 32'd0 : s_axis_tdata[159:128])};
            r_exp    <= {s_axis_tdata[223:160], s_axis_tdata[287:224],
                         s_axis_tdata[319:288]};
        end
        if (load_out) begin
            r_out_data  <= core_digest;
            r_out_match <= match_val;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_data[31:0], r_out_data[95:32], r_out_data[159:96]};
    assign m_axis_tuser  = r_out_match;

endmodule

### tb/tb.sv
// Self-checking bench for the keyed double SHA-1 challenge/response checker.
// Predicts digest and match flag per request and checks them in order against
// the response stream under random backpressure. Depends on scrc_pkg and the DUT.
module tb;
    import scrc_pkg::*;

    typedef enum logic {
        MODE_PRIMARY = 1'b0,
        MODE_BACKUP  = 1'b1
    } t_check_mode;

    typedef struct packed {
        t_check_mode mode;
        logic [63:0] chal_hi;
        logic [63:0] chal_mid;
        logic [31:0] chal_tail;
        logic [63:0] exp_hi;
        logic [63:0] exp_mid;
        logic [31:0] exp_tail;
    } t_request;

    typedef struct packed {
        logic [63:0] digest_first;
        logic [63:0] digest_second;
        logic [31:0] digest_tail;
        logic        matched;
    } t_response;

    localparam logic [31:0] ROUND_K0 = 32'h5A82_7999;
    localparam logic [31:0] ROUND_K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] ROUND_K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] ROUND_K3 = 32'hCA62_C1D6;

    localparam int unsigned IDLE_MAX       = 14;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 1500;
    localparam int unsigned KEY_PHASES     = 8;
    localparam int unsigned REQS_PER_PHASE = 230;
    localparam int unsigned PHASE_SETTLE   = 4;
    localparam int unsigned END_SETTLE     = 200;

    localparam logic [CFG_IDX_W-1:0] KEY_REGS [4] = '{
        CFG_KEY_A_UPPER, CFG_KEY_A_LOWER, CFG_KEY_B_UPPER, CFG_KEY_B_LOWER
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [63:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [319:0]         s_axis_tdata  = '0;
    logic [0:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [159:0]         m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    // key copy used by the predictor
    logic [63:0] key_a_hi = '0, key_a_lo = '0, key_b_hi = '0, key_b_lo = '0;

    t_request    queued_requests[$];
    t_response   awaited_responses[$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_wait      = 0;
    logic        req_taken      = 1'b0;
    logic        resp_taken     = 1'b0;
    logic        no_idle        = 1'b0;
    logic        squeeze_req    = 1'b0;
    logic        rx_hold        = 1'b0;

    sha1_challenge_response_check i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [159:0] sha1_compress(input logic [511:0] blk);
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 80; i++) begin
            t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = IV_A; b = IV_B; c = IV_C; d = IV_D; e = IV_E;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = ROUND_K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = ROUND_K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = ROUND_K2;
            end else begin
                f = b ^ c ^ d; k = ROUND_K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        return {IV_A + a, IV_B + b, IV_C + c, IV_D + d, IV_E + e};
    endfunction

    // 36-byte message key || data, padded into a single block
    function automatic logic [159:0] keyed_sha1(input logic [127:0] key, input logic [159:0] data);
        return sha1_compress({key, data, PAD_WORD, 160'd0, MSG_BIT_LEN});
    endfunction

    function automatic t_response predict_response(input t_request r);
        logic          backup;
        logic [127:0]  key;
        logic [159:0]  digest;
        t_response     resp;
        backup = (r.mode == MODE_BACKUP);
        key    = backup ? {key_b_hi, key_b_lo} : {key_a_hi, key_a_lo};
        digest = keyed_sha1(key, keyed_sha1(key,
                     {r.chal_hi, r.chal_mid, backup ? 32'd0 : r.chal_tail}));
        resp.digest_first  = digest[159:96];
        resp.digest_second = digest[95:32];
        resp.digest_tail   = digest[31:0];
        resp.matched = backup ? (digest[63:0] == r.exp_hi)
                              : (digest == {r.exp_hi, r.exp_mid, r.exp_tail});
        return resp;
    endfunction

    // sets the compared expected bytes to the correct digest
    function automatic t_request with_match(input t_request r);
        t_response p;
        p = predict_response(r);
        if (r.mode == MODE_BACKUP)
            r.exp_hi = {p.digest_second[31:0], p.digest_tail};
        else
            {r.exp_hi, r.exp_mid, r.exp_tail} = {p.digest_first, p.digest_second, p.digest_tail};
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic t_request random_request();
        t_request      r;
        int unsigned   shape;
        int unsigned   bit_idx;
        logic          fill_bit;
        logic [159:0]  exp_all;
        r.mode      = t_check_mode'($urandom_range(0, 1));
        r.chal_hi   = rand64();
        r.chal_mid  = rand64();
        r.chal_tail = $urandom;
        r.exp_hi    = rand64();
        r.exp_mid   = rand64();
        r.exp_tail  = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            fill_bit    = 1'($urandom_range(0, 1));
            r.chal_hi   = {64{fill_bit}};
            r.chal_mid  = {64{fill_bit}};
            r.chal_tail = {32{fill_bit}};
        end
        shape = $urandom_range(0, 99);
        // mostly correct responses, some off by a single bit, rest garbage
        if (shape < 70) begin
            r = with_match(r);
            if (shape >= 55) begin
                if (r.mode == MODE_BACKUP) begin
                    bit_idx = $urandom_range(0, 63);
                    r.exp_hi[bit_idx] = ~r.exp_hi[bit_idx];
                end else begin
                    bit_idx = $urandom_range(0, 159);
                    exp_all = {r.exp_hi, r.exp_mid, r.exp_tail};
                    exp_all[bit_idx] = ~exp_all[bit_idx];
                    {r.exp_hi, r.exp_mid, r.exp_tail} = exp_all;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_KEY_A_UPPER: key_a_hi = val;
            CFG_KEY_A_LOWER: key_a_lo = val;
            CFG_KEY_B_UPPER: key_b_hi = val;
            CFG_KEY_B_LOWER: key_b_lo = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle(input int unsigned settle);
        while (queued_requests.size() != 0 || s_axis_tvalid || awaited_responses.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // sample both streams at the rising edge
    always @(posedge i_clk) begin : sample_streams
        t_request  got_req;
        t_response want, seen;
        if (i_rst_n) begin
            req_taken  <= s_axis_tvalid && s_axis_tready;
            resp_taken <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                got_req.mode = t_check_mode'(s_axis_tuser[0]);
                {got_req.exp_tail, got_req.exp_mid, got_req.exp_hi,
                 got_req.chal_tail, got_req.chal_mid, got_req.chal_hi} = s_axis_tdata;
                awaited_responses.push_back(predict_response(got_req));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                {seen.digest_tail, seen.digest_second, seen.digest_first} = m_axis_tdata;
                seen.matched = m_axis_tuser[0];
                if (awaited_responses.size() == 0) begin
                    report_mismatch("response transaction with no request outstanding");
                end else begin
                    want = awaited_responses.pop_front();
                    check_field("digest_first", seen.digest_first, want.digest_first);
                    check_field("digest_second", seen.digest_second, want.digest_second);
                    check_field("digest_tail", 64'(seen.digest_tail), 64'(want.digest_tail));
                    check_field("matched", 64'(seen.matched), 64'(want.matched));
                end
            end
        end else begin
            req_taken  <= 1'b0;
            resp_taken <= 1'b0;
        end
    end

    // request driver; gap counts only while the block is ready
    always @(negedge i_clk) begin : drive_requests
        logic     next_valid;
        t_request next_req;
        next_valid = s_axis_tvalid;
        if (i_rst_n) begin
            if (req_taken) begin
                next_valid = 1'b0;
                send_gap   = draw_gap();
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    if (s_axis_tready === 1'b1) send_gap--;
                end else if (queued_requests.size() > 0) begin
                    next_req = queued_requests.pop_front();
                    s_axis_tdata <= {next_req.exp_tail, next_req.exp_mid, next_req.exp_hi,
                                     next_req.chal_tail, next_req.chal_mid, next_req.chal_hi};
                    s_axis_tuser <= next_req.mode;
                    next_valid = 1'b1;
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // response sink; stall counts only while a response is offered
    always @(negedge i_clk) begin : drive_ready
        logic next_ready;
        if (resp_taken) recv_wait = draw_gap();
        if (rx_hold) begin
            next_ready = 1'b0;
        end else if (recv_wait > 0) begin
            next_ready = 1'b0;
            if (m_axis_tvalid === 1'b1) recv_wait--;
        end else begin
            next_ready = 1'b1;
        end
        m_axis_tready <= next_ready;
    end

    // long sink hold-off so the block fills and stalls its input
    initial begin
        wait (squeeze_req);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_request    r;
        t_request    base;
        logic [63:0] key_set [4];
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests with the reset keys
        r = '{MODE_PRIMARY, '0, '0, '0, '0, '0, '0};
        queued_requests.push_back(r);
        r = '{MODE_PRIMARY, '1, '1, '1, '1, '1, '1};
        queued_requests.push_back(r);
        r = '{MODE_BACKUP, '0, '0, '0, '0, '0, '0};
        queued_requests.push_back(r);
        r = '{MODE_BACKUP, '1, '1, '1, '1, '1, '1};
        queued_requests.push_back(r);
        base = with_match('{MODE_PRIMARY, rand64(), rand64(), $urandom, '0, '0, '0});
        queued_requests.push_back(base);
        r = base; r.exp_tail[0] = ~r.exp_tail[0];
        queued_requests.push_back(r);
        r = base; r.exp_hi[63] = ~r.exp_hi[63];
        queued_requests.push_back(r);
        r = base; r.exp_mid[31] = ~r.exp_mid[31];
        queued_requests.push_back(r);
        // backup: tail of the challenge and the unused expected fields are ignored
        base = with_match('{MODE_BACKUP, rand64(), rand64(), '0, '0, '0, '0});
        queued_requests.push_back(base);
        r = base; r.chal_tail = '1; r.exp_mid = '1; r.exp_tail = '1;
        queued_requests.push_back(r);
        r = base; r.exp_hi[0] = ~r.exp_hi[0];
        queued_requests.push_back(r);
        r = base; r.exp_hi[63] = ~r.exp_hi[63];
        queued_requests.push_back(r);
        queued_requests.push_back(with_match('{MODE_PRIMARY, '1, '1, '1, '0, '0, '0}));
        queued_requests.push_back(with_match('{MODE_BACKUP, '1, '1, '1, '0, '1, '1}));
        wait_idle(PHASE_SETTLE);

        for (int p = 0; p < KEY_PHASES; p++) begin
            case (p)
                0: key_set = '{'1, '1, '1, '1};
                1: key_set = '{'0, '0, '0, '0};
                2: key_set = '{{32{2'b01}}, {32{2'b01}}, {32{2'b10}}, {32{2'b10}}};
                6: key_set = '{'1, '1, '0, '0};
                default: key_set = '{rand64(), rand64(), rand64(), rand64()};
            endcase
            for (int i = 0; i < 4; i++) write_key_reg(KEY_REGS[i], key_set[i]);
            // an index past the key registers must not alias onto one of them
            if (p == 0)
                write_key_reg({CFG_IDX_W{1'b1}}, '0);
            else
                write_key_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1,
                                                        CFG_KEY_B_LOWER + 1)), rand64());
            no_idle = (p == 3 || p == 5);
            for (int n = 0; n < REQS_PER_PHASE; n++) queued_requests.push_back(random_request());
            if (p == 1) squeeze_req = 1'b1;
            wait_idle(PHASE_SETTLE);
        end

        wait_idle(END_SETTLE);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
